@@ sv/depth_to_color_pixel_registration_assert.svh @@
// assertion macros for the depth to color registration block
// used by the top level only, no other dependencies
`ifndef DEPTH_TO_COLOR_PIXEL_REGISTRATION_ASSERT_SVH
`define DEPTH_TO_COLOR_PIXEL_REGISTRATION_ASSERT_SVH

// checked on every edge outside reset
`define DTC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define DTC_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/dtc_pkg.sv @@
// shared types, widths and register codes for depth to color registration
// no dependencies
package dtc_pkg;

   localparam int COORD_BITS     = 12;
   localparam int RAW_DEPTH_BITS = 16;

   localparam int PIX_BITS   = 12;
   localparam int DEPTH_BITS = 16;
   localparam int INTR_BITS  = 16;
   localparam int ROT_BITS   = 18;
   localparam int TRN_BITS   = 20;

   // centered pixel magnitude |col*16 - cx|, ray and transform widths
   localparam int MAG_BITS  = 16;
   localparam int DVD_BITS  = MAG_BITS + 16;
   localparam int RAY_BITS  = DVD_BITS + 1;
   localparam int PROD_BITS = RAY_BITS + ROT_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;
   localparam int QR_BITS   = SUM_BITS - 16;
   localparam int DQ_BITS   = QR_BITS + DEPTH_BITS + 1;
   localparam int PS_BITS   = DQ_BITS + 1;
   localparam int PT_BITS   = 46;

   // projection widths
   localparam int MUL_BITS = PT_BITS + INTR_BITS;
   localparam int NUM_BITS = MUL_BITS + 1;
   localparam int ABS_BITS = MUL_BITS;
   localparam int DEN_BITS = PT_BITS - 1 + 4;
   localparam int QUO_BITS = (COORD_BITS > PIX_BITS) ? COORD_BITS : PIX_BITS;
   localparam int CMP_BITS = (ABS_BITS > DEN_BITS + QUO_BITS) ? ABS_BITS : DEN_BITS + QUO_BITS;

   localparam logic signed [PT_BITS-1:0] PT_MAX = {1'b0, {(PT_BITS-1){1'b1}}};
   localparam logic signed [PT_BITS-1:0] PT_MIN = -PT_MAX;
   localparam logic [DEPTH_BITS-1:0] RAW_MASK = DEPTH_BITS'((1 << RAW_DEPTH_BITS) - 1);

   // register port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEPTH_MAX  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEPTH_INTR = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_COLOR_INTR = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_ROT_ROW0   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_ROT_ROW1   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_ROT_ROW2   = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_TRANS      = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_COLOR_SIZE = 3'd7;

   typedef struct packed {
      logic [PIX_BITS-1:0]   src_row;
      logic [PIX_BITS-1:0]   src_col;
      logic [DEPTH_BITS-1:0] raw_depth;
   } req_type;

   typedef struct packed {
      logic                  valid_res;
      logic [PIX_BITS-1:0]   dest_x;
      logic [PIX_BITS-1:0]   dest_y;
      logic [DEPTH_BITS-1:0] depth_mm;
   } rsp_type;

   typedef struct packed {
      logic [DEPTH_BITS-1:0] depth_max;
      logic [63:0]           depth_intrinsics;
      logic [63:0]           color_intrinsics;
      logic [53:0]           rotation_row0;
      logic [53:0]           rotation_row1;
      logic [53:0]           rotation_row2;
      logic [59:0]           translation_mm;
      logic [23:0]           color_size;
   } cfg_type;

   typedef struct packed {
      logic [DEPTH_BITS-1:0] depth_mm;
      logic                  neg_x;
      logic [MAG_BITS-1:0]   mag_x;
      logic                  neg_y;
      logic [MAG_BITS-1:0]   mag_y;
   } ray_in_type;

   typedef struct packed {
      logic [DEPTH_BITS-1:0]      depth_mm;
      logic signed [RAY_BITS-1:0] ray_x;
      logic signed [RAY_BITS-1:0] ray_y;
   } ray_out_type;

   typedef struct packed {
      logic [DEPTH_BITS-1:0]     depth_mm;
      logic                      ok;
      logic signed [PT_BITS-1:0] pt_x;
      logic signed [PT_BITS-1:0] pt_y;
      logic signed [PT_BITS-1:0] pt_z;
   } proj_in_type;

   typedef struct packed {
      logic [DEPTH_BITS-1:0] depth_mm;
      logic                  ok;
      logic                  neg_x;
      logic                  neg_y;
      logic                  ovf_x;
      logic                  ovf_y;
   } div_side_type;

endpackage

@@ sv/dtc_ray_div.sv @@
// depth ray divider: (centered pixel << 16) / focal length, one quotient bit per stage
// depends on dtc_pkg
module dtc_ray_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  dtc_pkg::cfg_type     cfg,
   input  logic                 in_v,
   input  dtc_pkg::ray_in_type  in_data,
   output logic                 out_v,
   output dtc_pkg::ray_out_type out_data
);
   localparam int N  = dtc_pkg::DVD_BITS;
   localparam int FB = dtc_pkg::INTR_BITS;

   logic [FB-1:0] fx, fy;
   assign fx = cfg.depth_intrinsics[15:0];
   assign fy = cfg.depth_intrinsics[31:16];

   // stage registers
   logic                v_ff     [N];
   dtc_pkg::ray_in_type side_ff  [N];
   logic [FB-1:0]       rem_x_ff [N];
   logic [FB-1:0]       rem_y_ff [N];
   logic [N-1:0]        dvd_x_ff [N];
   logic [N-1:0]        dvd_y_ff [N];

   // inputs seen by each stage
   logic                v_tap     [N];
   dtc_pkg::ray_in_type side_tap  [N];
   logic [FB-1:0]       rem_x_tap [N];
   logic [FB-1:0]       rem_y_tap [N];
   logic [N-1:0]        dvd_x_tap [N];
   logic [N-1:0]        dvd_y_tap [N];

   logic [FB:0]   t_x [N];
   logic [FB:0]   t_y [N];
   logic          ge_x [N];
   logic          ge_y [N];
   logic [FB-1:0] rem_x_in [N];
   logic [FB-1:0] rem_y_in [N];
   logic [N-1:0]  dvd_x_in [N];
   logic [N-1:0]  dvd_y_in [N];

   // restoring division step per stage
   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            v_tap[k]     = in_v;
            side_tap[k]  = in_data;
            rem_x_tap[k] = '0;
            rem_y_tap[k] = '0;
            dvd_x_tap[k] = {in_data.mag_x, 16'b0};
            dvd_y_tap[k] = {in_data.mag_y, 16'b0};
         end else begin
            v_tap[k]     = v_ff[k-1];
            side_tap[k]  = side_ff[k-1];
            rem_x_tap[k] = rem_x_ff[k-1];
            rem_y_tap[k] = rem_y_ff[k-1];
            dvd_x_tap[k] = dvd_x_ff[k-1];
            dvd_y_tap[k] = dvd_y_ff[k-1];
         end
         t_x[k]      = {rem_x_tap[k], dvd_x_tap[k][N-1]};
         t_y[k]      = {rem_y_tap[k], dvd_y_tap[k][N-1]};
         ge_x[k]     = t_x[k] >= {1'b0, fx};
         ge_y[k]     = t_y[k] >= {1'b0, fy};
         rem_x_in[k] = ge_x[k] ? FB'(t_x[k] - {1'b0, fx}) : t_x[k][FB-1:0];
         rem_y_in[k] = ge_y[k] ? FB'(t_y[k] - {1'b0, fy}) : t_y[k][FB-1:0];
         dvd_x_in[k] = {dvd_x_tap[k][N-2:0], ge_x[k]};
         dvd_y_in[k] = {dvd_y_tap[k][N-2:0], ge_y[k]};
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < N; k++) v_ff[k] <= v_tap[k];
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            side_ff[k]  <= side_tap[k];
            rem_x_ff[k] <= rem_x_in[k];
            rem_y_ff[k] <= rem_y_in[k];
            dvd_x_ff[k] <= dvd_x_in[k];
            dvd_y_ff[k] <= dvd_y_in[k];
         end
      end
   end

   // sign restore, truncation toward zero
   logic                        out_v_ff;
   dtc_pkg::ray_out_type        out_ff, out_in;
   logic signed [dtc_pkg::RAY_BITS-1:0] qx, qy;

   always_comb begin
      qx                = {1'b0, dvd_x_ff[N-1]};
      qy                = {1'b0, dvd_y_ff[N-1]};
      out_in.depth_mm   = side_ff[N-1].depth_mm;
      out_in.ray_x      = side_ff[N-1].neg_x ? -qx : qx;
      out_in.ray_y      = side_ff[N-1].neg_y ? -qy : qy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= v_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_v    = out_v_ff;
   assign out_data = out_ff;
endmodule

@@ sv/dtc_xform.sv @@
// rigid transform of the depth ray into the color camera, four stages
// depends on dtc_pkg
module dtc_xform (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  dtc_pkg::cfg_type     cfg,
   input  logic                 in_v,
   input  dtc_pkg::ray_out_type in_data,
   output logic                 out_v,
   output dtc_pkg::proj_in_type out_data
);
   localparam int PB = dtc_pkg::PROD_BITS;
   localparam int SB = dtc_pkg::SUM_BITS;
   localparam int QB = dtc_pkg::QR_BITS;
   localparam int DB = dtc_pkg::DQ_BITS;
   localparam int XB = dtc_pkg::PS_BITS;
   localparam int TB = dtc_pkg::PT_BITS;

   // rotation and translation fields per row
   logic signed [dtc_pkg::ROT_BITS-1:0] c_a [3];
   logic signed [dtc_pkg::ROT_BITS-1:0] c_b [3];
   logic signed [dtc_pkg::ROT_BITS-1:0] c_c [3];
   logic signed [dtc_pkg::TRN_BITS-1:0] trn [3];
   logic [53:0] rot [3];

   always_comb begin
      rot[0] = cfg.rotation_row0;
      rot[1] = cfg.rotation_row1;
      rot[2] = cfg.rotation_row2;
      for (int r = 0; r < 3; r++) begin
         c_a[r] = $signed(rot[r][17:0]);
         c_b[r] = $signed(rot[r][35:18]);
         c_c[r] = $signed(rot[r][53:36]);
         trn[r] = $signed(cfg.translation_mm[20*r +: 20]);
      end
   end

   logic                          v1_ff, v2_ff, v3_ff, v4_ff;
   logic                          ok1_ff, ok2_ff, ok3_ff, ok4_ff;
   logic [dtc_pkg::DEPTH_BITS-1:0] d1_ff, d2_ff, d3_ff, d4_ff;
   logic signed [PB-1:0] pa_ff [3], pa_in [3];
   logic signed [PB-1:0] pb_ff [3], pb_in [3];
   logic signed [SB-1:0] s_sum [3];
   logic signed [QB-1:0] q_ff [3], q_in [3];
   logic signed [DB-1:0] m_ff [3], m_in [3];
   logic signed [XB-1:0] p_sum [3];
   logic signed [TB-1:0] p_ff [3], p_in [3];
   logic signed [DB-1:0] d_sx;
   logic                 ok1_in;

   always_comb begin
      ok1_in = (in_data.depth_mm != '0) && (cfg.depth_intrinsics[15:0] != '0)
               && (cfg.depth_intrinsics[31:16] != '0);
      d_sx   = DB'($signed({1'b0, d2_ff}));
      for (int r = 0; r < 3; r++) begin
         // stage 1: ray products
         pa_in[r] = PB'(c_a[r]) * PB'(in_data.ray_x);
         pb_in[r] = PB'(c_b[r]) * PB'(in_data.ray_y);
         // stage 2: row sum, floor to whole ray units
         s_sum[r] = SB'(pa_ff[r]) + SB'(pb_ff[r]) + (SB'(c_c[r]) <<< 16);
         q_in[r]  = s_sum[r][SB-1:16];
         // stage 3: scale by depth
         m_in[r]  = d_sx * DB'(q_ff[r]);
         // stage 4: translate and clamp
         p_sum[r] = XB'(m_ff[r]) + (XB'(trn[r]) <<< 16);
         if (p_sum[r] > XB'(dtc_pkg::PT_MAX)) begin
            p_in[r] = dtc_pkg::PT_MAX;
         end else if (p_sum[r] < XB'(dtc_pkg::PT_MIN)) begin
            p_in[r] = dtc_pkg::PT_MIN;
         end else begin
            p_in[r] = TB'(p_sum[r]);
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_v;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff  <= in_data.depth_mm;
         d2_ff  <= d1_ff;
         d3_ff  <= d2_ff;
         d4_ff  <= d3_ff;
         ok1_ff <= ok1_in;
         ok2_ff <= ok1_ff;
         ok3_ff <= ok2_ff;
         ok4_ff <= ok3_ff;
         for (int r = 0; r < 3; r++) begin
            pa_ff[r] <= pa_in[r];
            pb_ff[r] <= pb_in[r];
            q_ff[r]  <= q_in[r];
            m_ff[r]  <= m_in[r];
            p_ff[r]  <= p_in[r];
         end
      end
   end

   assign out_v             = v4_ff;
   assign out_data.depth_mm = d4_ff;
   assign out_data.ok       = ok4_ff;
   assign out_data.pt_x     = p_ff[0];
   assign out_data.pt_y     = p_ff[1];
   assign out_data.pt_z     = p_ff[2];
endmodule

@@ sv/dtc_proj.sv @@
// color projection: intrinsics products, divide by 16*Z bit per stage, bounds check
// depends on dtc_pkg
module dtc_proj (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  dtc_pkg::cfg_type     cfg,
   input  logic                 in_v,
   input  dtc_pkg::proj_in_type in_data,
   output logic                 out_v,
   output dtc_pkg::rsp_type     out_data
);
   localparam int MB = dtc_pkg::MUL_BITS;
   localparam int NB = dtc_pkg::NUM_BITS;
   localparam int AB = dtc_pkg::ABS_BITS;
   localparam int EB = dtc_pkg::DEN_BITS;
   localparam int QN = dtc_pkg::QUO_BITS;
   localparam int CB = dtc_pkg::CMP_BITS;
   localparam int TB = dtc_pkg::PT_BITS;

   logic signed [MB-1:0] fxc, fyc, cxc, cyc;
   always_comb begin
      fxc = MB'($signed({1'b0, cfg.color_intrinsics[15:0]}));
      fyc = MB'($signed({1'b0, cfg.color_intrinsics[31:16]}));
      cxc = MB'($signed({1'b0, cfg.color_intrinsics[47:32]}));
      cyc = MB'($signed({1'b0, cfg.color_intrinsics[63:48]}));
   end

   // front stages
   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic                 ok1_ff, ok2_ff, ok3_ff;
   logic [dtc_pkg::DEPTH_BITS-1:0] d1_ff, d2_ff, d3_ff;
   logic signed [MB-1:0] ax_ff, az_ff, by_ff, bz_ff;
   logic signed [TB-1:0] z1_ff;
   logic signed [NB-1:0] nu_ff, nv_ff, nu_in, nv_in;
   logic [EB-1:0]        den2_ff, den3_ff, den4_ff;
   logic                 neg_u_ff, neg_v_ff;
   logic [AB-1:0]        mag_u_ff, mag_v_ff;
   dtc_pkg::div_side_type side4_ff, side4_in;
   logic [CB-1:0]        rem_u4_ff, rem_v4_ff;

   always_comb begin
      nu_in             = NB'(ax_ff) + NB'(az_ff);
      nv_in             = NB'(by_ff) + NB'(bz_ff);
      side4_in.depth_mm = d3_ff;
      side4_in.ok       = ok3_ff;
      side4_in.neg_x    = neg_u_ff;
      side4_in.neg_y    = neg_v_ff;
      side4_in.ovf_x    = CB'(mag_u_ff) >= (CB'(den3_ff) << QN);
      side4_in.ovf_y    = CB'(mag_v_ff) >= (CB'(den3_ff) << QN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_v;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // products with the color intrinsics
         ax_ff    <= fxc * MB'(in_data.pt_x);
         az_ff    <= cxc * MB'(in_data.pt_z);
         by_ff    <= fyc * MB'(in_data.pt_y);
         bz_ff    <= cyc * MB'(in_data.pt_z);
         z1_ff    <= in_data.pt_z;
         d1_ff    <= in_data.depth_mm;
         ok1_ff   <= in_data.ok && (in_data.pt_z > 0);
         // numerators and divisor 16*Z
         nu_ff    <= nu_in;
         nv_ff    <= nv_in;
         den2_ff  <= {z1_ff[TB-2:0], 4'b0};
         d2_ff    <= d1_ff;
         ok2_ff   <= ok1_ff;
         // magnitudes
         neg_u_ff <= nu_ff[NB-1];
         neg_v_ff <= nv_ff[NB-1];
         mag_u_ff <= AB'(nu_ff[NB-1] ? -nu_ff : nu_ff);
         mag_v_ff <= AB'(nv_ff[NB-1] ? -nv_ff : nv_ff);
         den3_ff  <= den2_ff;
         d3_ff    <= d2_ff;
         ok3_ff   <= ok2_ff;
         // range check ahead of the divider
         side4_ff  <= side4_in;
         den4_ff   <= den3_ff;
         rem_u4_ff <= CB'(mag_u_ff);
         rem_v4_ff <= CB'(mag_v_ff);
      end
   end

   // divider stages, most significant quotient bit first
   logic                  dv_ff    [QN];
   dtc_pkg::div_side_type side_ff  [QN];
   logic [EB-1:0]         den_ff   [QN];
   logic [CB-1:0]         rem_u_ff [QN];
   logic [CB-1:0]         rem_v_ff [QN];
   logic [QN-1:0]         q_u_ff   [QN];
   logic [QN-1:0]         q_v_ff   [QN];

   logic                  dv_tap    [QN];
   dtc_pkg::div_side_type side_tap  [QN];
   logic [EB-1:0]         den_tap   [QN];
   logic [CB-1:0]         rem_u_tap [QN];
   logic [CB-1:0]         rem_v_tap [QN];
   logic [QN-1:0]         q_u_tap   [QN];
   logic [QN-1:0]         q_v_tap   [QN];
   logic [CB-1:0]         sh        [QN];
   logic                  ge_u      [QN];
   logic                  ge_v      [QN];
   logic [CB-1:0]         rem_u_in  [QN];
   logic [CB-1:0]         rem_v_in  [QN];
   logic [QN-1:0]         q_u_in    [QN];
   logic [QN-1:0]         q_v_in    [QN];

   always_comb begin
      for (int k = 0; k < QN; k++) begin
         if (k == 0) begin
            dv_tap[k]    = v4_ff;
            side_tap[k]  = side4_ff;
            den_tap[k]   = den4_ff;
            rem_u_tap[k] = rem_u4_ff;
            rem_v_tap[k] = rem_v4_ff;
            q_u_tap[k]   = '0;
            q_v_tap[k]   = '0;
         end else begin
            dv_tap[k]    = dv_ff[k-1];
            side_tap[k]  = side_ff[k-1];
            den_tap[k]   = den_ff[k-1];
            rem_u_tap[k] = rem_u_ff[k-1];
            rem_v_tap[k] = rem_v_ff[k-1];
            q_u_tap[k]   = q_u_ff[k-1];
            q_v_tap[k]   = q_v_ff[k-1];
         end
         sh[k]       = CB'(den_tap[k]) << (QN - 1 - k);
         ge_u[k]     = rem_u_tap[k] >= sh[k];
         ge_v[k]     = rem_v_tap[k] >= sh[k];
         rem_u_in[k] = ge_u[k] ? rem_u_tap[k] - sh[k] : rem_u_tap[k];
         rem_v_in[k] = ge_v[k] ? rem_v_tap[k] - sh[k] : rem_v_tap[k];
         q_u_in[k]   = {q_u_tap[k][QN-2:0], ge_u[k]};
         q_v_in[k]   = {q_v_tap[k][QN-2:0], ge_v[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QN; k++) dv_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < QN; k++) dv_ff[k] <= dv_tap[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QN; k++) begin
            side_ff[k]  <= side_tap[k];
            den_ff[k]   <= den_tap[k];
            rem_u_ff[k] <= rem_u_in[k];
            rem_v_ff[k] <= rem_v_in[k];
            q_u_ff[k]   <= q_u_in[k];
            q_v_ff[k]   <= q_v_in[k];
         end
      end
   end

   // bounds check against the color image size
   dtc_pkg::div_side_type fin;
   logic [QN-1:0]         qu, qv;
   logic                  hit;
   logic                  out_v_ff;
   dtc_pkg::rsp_type      out_ff, out_in;

   always_comb begin
      fin  = side_ff[QN-1];
      qu   = q_u_ff[QN-1];
      qv   = q_v_ff[QN-1];
      hit  = fin.ok && !fin.ovf_x && !fin.ovf_y
             && (!fin.neg_x || qu == '0) && (!fin.neg_y || qv == '0)
             && (16'(qu) < 16'(cfg.color_size[dtc_pkg::COORD_BITS-1:0]))
             && (16'(qv) < 16'(cfg.color_size[2*dtc_pkg::COORD_BITS-1:dtc_pkg::COORD_BITS]));
      out_in.valid_res = hit;
      out_in.dest_x    = hit ? dtc_pkg::PIX_BITS'(qu) : '0;
      out_in.dest_y    = hit ? dtc_pkg::PIX_BITS'(qv) : '0;
      out_in.depth_mm  = fin.depth_mm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= dv_ff[QN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_v    = out_v_ff;
   assign out_data = out_ff;
endmodule

@@ sv/depth_to_color_pixel_registration.sv @@
// channel | dir | handshake            | payload
// req     | in  | req_valid, req_ready | dtc_pkg::req_type
// rsp     | out | rsp_valid, rsp_ready | dtc_pkg::rsp_type
// csr     | in  | csr_we               | csr_index, csr_wdata
//
// one pixel per cycle sustained unless the skid is full; the two restoring
// dividers have 32 ray stages and 12 projection stages, one quotient bit per stage
// synchronous reset clears all valid bits and the configuration registers;
// payload registers are not reset
// a result that arrives while the output is stalled parks in a skid register,
// which freezes the whole pipeline and drops req_ready until the skid drains
// depends on dtc_pkg, dtc_ray_div, dtc_xform, dtc_proj and the assertion header
`include "depth_to_color_pixel_registration_assert.svh"

module depth_to_color_pixel_registration (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  dtc_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output dtc_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [dtc_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [dtc_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   // configuration registers
   dtc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            dtc_pkg::REG_DEPTH_MAX:  cfg_in.depth_max        = csr_wdata[15:0];
            dtc_pkg::REG_DEPTH_INTR: cfg_in.depth_intrinsics = csr_wdata;
            dtc_pkg::REG_COLOR_INTR: cfg_in.color_intrinsics = csr_wdata;
            dtc_pkg::REG_ROT_ROW0:   cfg_in.rotation_row0    = csr_wdata[53:0];
            dtc_pkg::REG_ROT_ROW1:   cfg_in.rotation_row1    = csr_wdata[53:0];
            dtc_pkg::REG_ROT_ROW2:   cfg_in.rotation_row2    = csr_wdata[53:0];
            dtc_pkg::REG_TRANS:      cfg_in.translation_mm   = csr_wdata[59:0];
            dtc_pkg::REG_COLOR_SIZE: cfg_in.color_size       = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline enable: everything moves unless the skid is occupied
   logic skid_v_ff, skid_v_in;
   logic en;
   assign en        = !skid_v_ff;
   assign req_ready = en;

   // front stage: depth scaling and centering
   logic                                f_v_ff;
   dtc_pkg::ray_in_type                 f_ff, f_in;
   logic [2*dtc_pkg::DEPTH_BITS-1:0]    dprod;
   logic signed [dtc_pkg::MAG_BITS:0]   cx_n, cy_n;

   always_comb begin
      dprod = (2*dtc_pkg::DEPTH_BITS)'(req_data.raw_depth & dtc_pkg::RAW_MASK)
              * (2*dtc_pkg::DEPTH_BITS)'(cfg_ff.depth_max);
      cx_n  = $signed({1'b0, req_data.src_col, 4'b0}) - $signed({1'b0, cfg_ff.depth_intrinsics[47:32]});
      cy_n  = $signed({1'b0, req_data.src_row, 4'b0}) - $signed({1'b0, cfg_ff.depth_intrinsics[63:48]});
      f_in.depth_mm = dprod[2*dtc_pkg::DEPTH_BITS-1:dtc_pkg::DEPTH_BITS];
      f_in.neg_x    = cx_n[dtc_pkg::MAG_BITS];
      f_in.neg_y    = cy_n[dtc_pkg::MAG_BITS];
      f_in.mag_x    = dtc_pkg::MAG_BITS'(cx_n[dtc_pkg::MAG_BITS] ? -cx_n : cx_n);
      f_in.mag_y    = dtc_pkg::MAG_BITS'(cy_n[dtc_pkg::MAG_BITS] ? -cy_n : cy_n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (en) begin
         f_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff <= f_in;
      end
   end

   // ray division, transform, projection
   logic                 r_v, x_v, p_v;
   dtc_pkg::ray_out_type r_data;
   dtc_pkg::proj_in_type x_data;
   dtc_pkg::rsp_type     p_data;

   dtc_ray_div u_ray_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .cfg      (cfg_ff),
      .in_v     (f_v_ff),
      .in_data  (f_ff),
      .out_v    (r_v),
      .out_data (r_data)
   );

   dtc_xform u_xform (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .cfg      (cfg_ff),
      .in_v     (r_v),
      .in_data  (r_data),
      .out_v    (x_v),
      .out_data (x_data)
   );

   dtc_proj u_proj (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .cfg      (cfg_ff),
      .in_v     (x_v),
      .in_data  (x_data),
      .out_v    (p_v),
      .out_data (p_data)
   );

   // output register plus skid
   logic             out_v_ff, out_v_in;
   dtc_pkg::rsp_type out_ff, out_in, skid_ff, skid_in;
   logic             take;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      take      = p_v && en;
      if (skid_v_ff) begin
         if (rsp_ready) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (!out_v_ff || rsp_ready) begin
         out_v_in = take;
         out_in   = p_data;
      end else if (take) begin
         skid_v_in = 1'b1;
         skid_in   = p_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // checks
   `DTC_ASSERT(a_skid_needs_out, skid_v_ff |-> out_v_ff, "skid holds a result with output empty")
   `DTC_ASSERT(a_skid_fill, $rose(skid_v_ff) |-> $past(rsp_valid && !rsp_ready), "skid filled without a stall")
   `DTC_ASSERT(a_miss_zero, rsp_valid && !rsp_data.valid_res |-> rsp_data.dest_x == '0 && rsp_data.dest_y == '0, "miss with nonzero coordinates")
   `DTC_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid && req_ready, "pipeline not empty after reset")
endmodule
